>>> rtl/core/pixel_block_binning_sum_macros.svh
// Assertion macros shared by the binning checker.
`ifndef PIXEL_BLOCK_BINNING_SUM_MACROS_SVH
`define PIXEL_BLOCK_BINNING_SUM_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define PBBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define PBBS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pbbs_pkg.sv
// Shared constants, register codes and control structs for the binning block.
`timescale 1ns / 1ps
`default_nettype none

package pbbs_pkg;

  localparam int MAX_BINS_ACROSS = 256;
  localparam int MAX_FRAME_DIM   = 4096;
  localparam int MAX_BIN_SIZE    = 64;
  localparam int PIXEL_BITS      = 32;
  localparam int SUM_BITS        = 44;

  localparam int FDIM_W  = $clog2(MAX_FRAME_DIM + 1);    // frame size / bins_down reg
  localparam int POS_W   = $clog2(MAX_FRAME_DIM);        // pixel position
  localparam int BA_W    = $clog2(MAX_BINS_ACROSS + 1);  // bins_across reg, coarse column
  localparam int ADDR_W  = $clog2(MAX_BINS_ACROSS);      // accumulator address
  localparam int BS_W    = $clog2(MAX_BIN_SIZE + 1);     // bin size reg
  localparam int BCNT_W  = $clog2(MAX_BIN_SIZE);         // position inside a bin
  localparam int GROWS_W = FDIM_W + BS_W;                // bins_down * bin_height
  localparam int GCOLS_W = BA_W + BS_W;                  // bins_across * bin_width

  localparam int OUT_ROW_W = 12;
  localparam int OUT_COL_W = 8;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 64;

  localparam int CFG_W     = FDIM_W;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_BINS_ACROSS  = 3'd2,
    REG_BINS_DOWN    = 3'd3,
    REG_BIN_WIDTH    = 3'd4,
    REG_BIN_HEIGHT   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [FDIM_W-1:0]  frame_width;
    logic [FDIM_W-1:0]  frame_height;
    logic [BA_W-1:0]    bins_across;
    logic [FDIM_W-1:0]  bins_down;
    logic [BS_W-1:0]    bin_width;
    logic [BS_W-1:0]    bin_height;
    logic [GROWS_W-1:0] grid_rows;
    logic [GCOLS_W-1:0] grid_cols;
  } cfg_t;

  // Per-pixel control decided by the scan counters.
  typedef struct packed {
    logic                 in_grid;
    logic                 seg_end;
    logic                 first_row;
    logic                 last_row;
    logic                 row_wrap;
    logic                 frame_done;
    logic [ADDR_W-1:0]    addr;
    logic [OUT_ROW_W-1:0] out_row;
    logic [OUT_COL_W-1:0] out_col;
  } tag_t;

endpackage

`default_nettype wire

>>> rtl/core/pixel_block_binning_sum.sv
// Top level of the streaming pixel block binning sum.
//
// Pixels of a frame enter on the s_ stream in row-major order, one request
// per cycle. Each bin of bin_height x bin_width pixels is summed exactly in
// 44-bit signed Q44.0 and leaves on the m_ stream with its coarse row and column;
// m_tlast marks the frame's last bin. Pixels outside the bin grid only
// advance the raster position.
// Throughput: one pixel per cycle, sustained, as long as results are taken.
// A pixel that closes a bin shows its sum on m_ after passing the input
// register, then the result register.
// The per-column accumulator memory has one write and one registered read
// port; a same-column read at the edge of its write is forwarded.
// Configuration: cfg_we/cfg_addr/cfg_wdata, one register per cycle; the user must
// write only while no pixel is in flight (unchecked); grid extents follow next cycle.
// Reset (rst, synchronous) puts the raster at the frame origin and restores
// register defaults; accumulator contents are not cleared.
// When m_tready stays low one finished result waits in the output register;
// pixels that close no bin keep flowing, and the next bin-closing pixel is
// held in the input register, dropping s_tready until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module pixel_block_binning_sum (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pbbs_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [pbbs_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pbbs_pkg::IN_TDATA_W-1:0]     s_tdata,   // [31:0] pixel_value
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pbbs_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [43:0] bin_sum, [55:44] out_row,
                                                         // [63:56] out_col
  output logic                                m_tlast    // frame_done
);

  pbbs_pkg::cfg_t cfg;
  pbbs_pkg::tag_t tag;

  logic signed [pbbs_pkg::SUM_BITS-1:0] bin_sum;
  logic [pbbs_pkg::OUT_ROW_W-1:0]       out_row;
  logic [pbbs_pkg::OUT_COL_W-1:0]       out_col;
  logic                                 accept;

  assign accept = s_tvalid && s_tready;

  pbbs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pbbs_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .tag    (tag)
  );

  pbbs_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_pixel  (s_tdata[pbbs_pkg::PIXEL_BITS-1:0]),
    .in_tag    (tag),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_sum   (bin_sum),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_done  (m_tlast)
  );

  assign m_tdata = {out_col, out_row, bin_sum};

endmodule

`default_nettype wire

>>> rtl/core/pbbs_cfg.sv
// Configuration registers with clamping and precomputed grid extents.
`timescale 1ns / 1ps
`default_nettype none

module pbbs_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pbbs_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [pbbs_pkg::CFG_W-1:0]       cfg_wdata,
  output pbbs_pkg::cfg_t                   cfg
);

  localparam int CW  = pbbs_pkg::CFG_W;
  localparam int FDW = pbbs_pkg::FDIM_W;
  localparam int BAW = pbbs_pkg::BA_W;
  localparam int BSW = pbbs_pkg::BS_W;
  localparam int GRW = pbbs_pkg::GROWS_W;
  localparam int GCW = pbbs_pkg::GCOLS_W;

  function automatic logic [CW-1:0] clamp(input logic [CW-1:0] v, input logic [CW-1:0] hi);
    logic [CW-1:0] r;
    if (v == '0) r = CW'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  logic [FDW-1:0] frame_width, frame_height, bins_down;
  logic [BAW-1:0] bins_across;
  logic [BSW-1:0] bin_width, bin_height;
  logic [GRW-1:0] grid_rows;
  logic [GCW-1:0] grid_cols;

  logic [CW-1:0] fdim_val, ba_val, bs_val;

  always_comb begin
    fdim_val = clamp(cfg_wdata[FDW-1:0], CW'(pbbs_pkg::MAX_FRAME_DIM));
    ba_val   = clamp(CW'(cfg_wdata[BAW-1:0]), CW'(pbbs_pkg::MAX_BINS_ACROSS));
    bs_val   = clamp(CW'(cfg_wdata[BSW-1:0]), CW'(pbbs_pkg::MAX_BIN_SIZE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FDW'(1024);
      frame_height <= FDW'(1024);
      bins_across  <= BAW'(64);
      bins_down    <= FDW'(64);
      bin_width    <= BSW'(16);
      bin_height   <= BSW'(16);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pbbs_pkg::REG_FRAME_WIDTH:  frame_width  <= fdim_val[FDW-1:0];
        pbbs_pkg::REG_FRAME_HEIGHT: frame_height <= fdim_val[FDW-1:0];
        pbbs_pkg::REG_BINS_ACROSS:  bins_across  <= ba_val[BAW-1:0];
        pbbs_pkg::REG_BINS_DOWN:    bins_down    <= fdim_val[FDW-1:0];
        pbbs_pkg::REG_BIN_WIDTH:    bin_width    <= bs_val[BSW-1:0];
        pbbs_pkg::REG_BIN_HEIGHT:   bin_height   <= bs_val[BSW-1:0];
        default: ;
      endcase
    end
  end

  // Grid extents follow the registers in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= GRW'(1024);
      grid_cols <= GCW'(1024);
    end else begin
      grid_rows <= GRW'(bins_down) * GRW'(bin_height);
      grid_cols <= GCW'(bins_across) * GCW'(bin_width);
    end
  end

  always_comb begin
    cfg.frame_width  = frame_width;
    cfg.frame_height = frame_height;
    cfg.bins_across  = bins_across;
    cfg.bins_down    = bins_down;
    cfg.bin_width    = bin_width;
    cfg.bin_height   = bin_height;
    cfg.grid_rows    = grid_rows;
    cfg.grid_cols    = grid_cols;
  end

endmodule

`default_nettype wire

>>> rtl/core/pbbs_scan.sv
// Raster position counters: classify each incoming pixel against the bin grid.
`timescale 1ns / 1ps
`default_nettype none

module pbbs_scan (
  input  logic            clk,
  input  logic            rst,
  input  pbbs_pkg::cfg_t  cfg,
  input  logic            accept,
  output pbbs_pkg::tag_t  tag
);

  localparam int POSW = pbbs_pkg::POS_W;
  localparam int FDW  = pbbs_pkg::FDIM_W;
  localparam int BAW  = pbbs_pkg::BA_W;
  localparam int BSW  = pbbs_pkg::BS_W;
  localparam int BCW  = pbbs_pkg::BCNT_W;
  localparam int GRW  = pbbs_pkg::GROWS_W;
  localparam int GCW  = pbbs_pkg::GCOLS_W;
  localparam int AW   = pbbs_pkg::ADDR_W;
  localparam int ORW  = pbbs_pkg::OUT_ROW_W;
  localparam int OCW  = pbbs_pkg::OUT_COL_W;

  logic [POSW-1:0] pixel_column, pixel_row;
  logic [BCW-1:0]  column_in_bin, row_in_bin;
  logic [BAW-1:0]  coarse_column;
  logic [FDW-1:0]  coarse_row;

  logic [POSW-1:0] pixel_column_next, pixel_row_next;
  logic [BCW-1:0]  column_in_bin_next, row_in_bin_next;
  logic [BAW-1:0]  coarse_column_next;
  logic [FDW-1:0]  coarse_row_next;

  logic row_in_grid, in_grid, seg_end, last_row, pcol_end, prow_end;

  always_comb begin
    row_in_grid = (GRW'(pixel_row) < cfg.grid_rows) && (coarse_row < cfg.bins_down);
    in_grid     = row_in_grid && (GCW'(pixel_column) < cfg.grid_cols)
                  && (coarse_column < cfg.bins_across);
    seg_end     = in_grid && ((BSW'(column_in_bin) + BSW'(1)) >= cfg.bin_width);
    last_row    = (BSW'(row_in_bin) + BSW'(1)) >= cfg.bin_height;
    pcol_end    = (FDW'(pixel_column) + FDW'(1)) >= cfg.frame_width;
    prow_end    = (FDW'(pixel_row) + FDW'(1)) >= cfg.frame_height;

    tag.in_grid    = in_grid;
    tag.seg_end    = seg_end;
    tag.first_row  = (row_in_bin == '0);
    tag.last_row   = last_row;
    tag.row_wrap   = pcol_end;
    tag.frame_done = ((coarse_row + FDW'(1)) >= cfg.bins_down)
                     && ((coarse_column + BAW'(1)) >= cfg.bins_across);
    tag.addr       = coarse_column[AW-1:0];
    tag.out_row    = coarse_row[ORW-1:0];
    tag.out_col    = coarse_column[OCW-1:0];
  end

  always_comb begin
    pixel_column_next  = pixel_column;
    pixel_row_next     = pixel_row;
    column_in_bin_next = column_in_bin;
    row_in_bin_next    = row_in_bin;
    coarse_column_next = coarse_column;
    coarse_row_next    = coarse_row;

    if (in_grid) begin
      if (seg_end) begin
        column_in_bin_next = '0;
        coarse_column_next = coarse_column + BAW'(1);
      end else begin
        column_in_bin_next = column_in_bin + BCW'(1);
      end
    end

    if (pcol_end) begin
      if (prow_end) begin
        // frame complete: everything back to the origin
        pixel_column_next  = '0;
        pixel_row_next     = '0;
        column_in_bin_next = '0;
        row_in_bin_next    = '0;
        coarse_column_next = '0;
        coarse_row_next    = '0;
      end else begin
        pixel_column_next  = '0;
        column_in_bin_next = '0;
        coarse_column_next = '0;
        if (row_in_grid) begin
          if (last_row) begin
            row_in_bin_next = '0;
            coarse_row_next = coarse_row + FDW'(1);
          end else begin
            row_in_bin_next = row_in_bin + BCW'(1);
          end
        end
        pixel_row_next = pixel_row + POSW'(1);
      end
    end else begin
      pixel_column_next = pixel_column + POSW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column  <= '0;
      pixel_row     <= '0;
      column_in_bin <= '0;
      row_in_bin    <= '0;
      coarse_column <= '0;
      coarse_row    <= '0;
    end else if (accept) begin
      pixel_column  <= pixel_column_next;
      pixel_row     <= pixel_row_next;
      column_in_bin <= column_in_bin_next;
      row_in_bin    <= row_in_bin_next;
      coarse_column <= coarse_column_next;
      coarse_row    <= coarse_row_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pbbs_accum.sv
// Summing stage: run sum, per-column accumulator memory and result register.
`timescale 1ns / 1ps
`default_nettype none

module pbbs_accum (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pbbs_pkg::PIXEL_BITS-1:0] in_pixel,
  input  pbbs_pkg::tag_t                        in_tag,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pbbs_pkg::SUM_BITS-1:0]  out_sum,
  output logic [pbbs_pkg::OUT_ROW_W-1:0]        out_row,
  output logic [pbbs_pkg::OUT_COL_W-1:0]        out_col,
  output logic                                  out_done
);

  localparam int SW = pbbs_pkg::SUM_BITS;
  localparam int PW = pbbs_pkg::PIXEL_BITS;

  logic accept;

  // stage 1: one registered pixel with its control
  logic                 s1_valid;
  pbbs_pkg::tag_t       s1_tag;
  logic signed [PW-1:0] s1_px;
  logic                 fwd_hit;
  logic [SW-1:0]        fwd_data;
  logic [SW-1:0]        rdata;
  logic [SW-1:0]        run_sum;

  logic [SW-1:0] acc_mem [pbbs_pkg::MAX_BINS_ACROSS];

  logic [SW-1:0] px_ext, prev, total;
  logic          s1_emit, s1_wr, s1_move;

  always_comb begin
    px_ext   = {{(SW-PW){s1_px[PW-1]}}, s1_px};
    prev     = s1_tag.first_row ? '0 : (fwd_hit ? fwd_data : rdata);
    total    = prev + run_sum + px_ext;
    s1_emit  = s1_tag.seg_end && s1_tag.last_row;
    s1_wr    = s1_tag.seg_end && !s1_tag.last_row;
    s1_move  = s1_valid && (!s1_emit || !out_valid || out_ready);
    in_ready = !s1_valid || s1_move;
    accept   = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tag   <= in_tag;
      s1_px    <= in_pixel;
      // the read below misses a write landing at this same edge
      fwd_hit  <= s1_move && s1_wr && (s1_tag.addr == in_tag.addr);
      fwd_data <= total;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_wr) begin
      acc_mem[s1_tag.addr] <= total;
    end
    if (accept) begin
      rdata <= acc_mem[in_tag.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum <= '0;
    end else if (s1_move) begin
      if (s1_tag.seg_end || s1_tag.row_wrap) begin
        run_sum <= '0;
      end else if (s1_tag.in_grid) begin
        run_sum <= run_sum + px_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_emit) begin
      out_sum  <= total;
      out_row  <= s1_tag.out_row;
      out_col  <= s1_tag.out_col;
      out_done <= s1_tag.frame_done;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pbbs_checker.sv
// Port-level assertions for the binning block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

`include "pixel_block_binning_sum_macros.svh"

module pbbs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [pbbs_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                             m_tlast
);

  // a result waiting for the receiver must not change
  `PBBS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

  // input is only held off by a full, stalled result register
  `PBBS_ASSERT_IMP(a_in_free, !m_tvalid || m_tready, s_tready, "input stalled with free output")

  // a fresh result must trace back to an accepted source pixel
  `PBBS_ASSERT_IMP(a_out_src, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "result without a source pixel")

  // no result is offered in the first cycle out of reset
  `PBBS_ASSERT_IMP(a_rst_idle, $fell(rst), !m_tvalid, "result valid right after reset")

endmodule

bind pixel_block_binning_sum pbbs_checker u_pbbs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
